// File: design/hnm_pkg.sv
package hnm_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int RING_BITS  = 4;
   localparam int COL_BITS   = 12;
   localparam int HGT_BITS   = 16;
   localparam int ADDR_BITS  = RING_BITS + COL_BITS;
   localparam int RAM_DEPTH  = 2 ** ADDR_BITS;

   typedef logic [12:0]           dim_type;
   typedef logic [COL_BITS-1:0]   coord_type;
   typedef logic [HGT_BITS-1:0]   hgt_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;

   typedef struct packed {
      dim_type w;
      dim_type h;
      logic    smooth;
   } geo_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_GAIN   = 2'd2,
      CSR_SMOOTH = 2'd3
   } csr_type;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   typedef enum logic [1:0] {
      T_IDLE,
      T_FETCH,
      T_CALC,
      T_OUT
   } top_state_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_ISSUE,
      F_DRAIN
   } fetch_state_type;

   typedef enum logic [2:0] {
      N_IDLE,
      N_SLOPE,
      N_SQUARE,
      N_ROOT_INIT,
      N_ROOT,
      N_DIV_INIT,
      N_DIV
   } norm_state_type;

   function automatic dim_type clamp_dim(input dim_type v, input dim_type maxv);
      dim_type r;
      r = v;
      if (v == '0) begin
         r = 13'd1;
      end else if (v > maxv) begin
         r = maxv;
      end
      return r;
   endfunction

   // Clamp a signed coordinate into 0..n-1
   function automatic dim_type clamp_coord(input logic signed [14:0] v, input dim_type n);
      dim_type r;
      r = v[12:0];
      if (v < 15'sd0) begin
         r = '0;
      end else if (v >= $signed({2'b00, n})) begin
         r = n - 13'd1;
      end
      return r;
   endfunction

   // Rounded divide by 5 through a reciprocal multiply
   function automatic hgt_type div5r(input logic [18:0] s);
      logic [39:0] p;
      p = 40'(s + 19'd2) * 40'd838861;
      return p[37:22];
   endfunction

   function automatic hgt_type luma(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b);
      logic [23:0] s;
      s = 24'(r) * 24'd19672 + 24'(g) * 24'd38620 + 24'(b) * 24'd7500 + 24'd128;
      return s[23:8];
   endfunction

endpackage

// File: design/hnm_ram.sv
module hnm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/hnm_fetch.sv
module hnm_fetch (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  hnm_pkg::geo_type               geo,
   input  hnm_pkg::coord_type             ox,
   input  hnm_pkg::coord_type             oy,
   output logic                           rd_en,
   output hnm_pkg::addr_type              rd_addr,
   input  hnm_pkg::hgt_type               rd_data,
   output logic                           done,
   output logic [3:0][hnm_pkg::HGT_BITS-1:0] hgt
);
   import hnm_pkg::*;

   typedef struct packed {
      logic       valid;
      logic [1:0] pt;
      logic       first_h;
      logic       last_h;
      logic       first_v;
      logic       last_v;
   } tag_type;

   fetch_state_type state_ff, state_in;
   logic [1:0] pt_ff, pt_in;
   logic [2:0] vk_ff, vk_in, hk_ff, hk_in, lim;
   tag_type    tag_d_ff, tag_e_ff, tag_f_ff, tag_issue, tag_e_in, tag_f_in;
   logic [18:0] hsum_ff, hsum_in, hfull_ff, vsum_ff, vsum_in, vfull_ff;
   hgt_type     hb, val;
   logic [3:0][HGT_BITS-1:0] hgt_ff;
   logic        done_ff;
   logic signed [14:0] sx, sy, cx, cy, off_h, off_v;
   dim_type     tx, ty;

   assign lim = geo.smooth ? 3'd4 : 3'd0;

   // Center point of the current height sample, clamped first
   always_comb begin
      sx = $signed({3'b000, ox});
      sy = $signed({3'b000, oy});
      cx = sx;
      cy = sy;
      case (pt_ff)
         2'd0: cx = $signed({2'b00, clamp_coord(sx + 15'sd1, geo.w)});
         2'd1: cx = $signed({2'b00, clamp_coord(sx - 15'sd1, geo.w)});
         2'd2: cy = $signed({2'b00, clamp_coord(sy + 15'sd1, geo.h)});
         2'd3: cy = $signed({2'b00, clamp_coord(sy - 15'sd1, geo.h)});
         default: cx = sx;
      endcase
      off_h = geo.smooth ? $signed({12'd0, hk_ff}) - 15'sd2 : 15'sd0;
      off_v = geo.smooth ? $signed({12'd0, vk_ff}) - 15'sd2 : 15'sd0;
      tx = clamp_coord(cx + off_h, geo.w);
      ty = clamp_coord(cy + off_v, geo.h);
   end

   assign rd_addr = {ty[RING_BITS-1:0], tx[COL_BITS-1:0]};
   assign rd_en   = (state_ff == F_ISSUE);

   always_comb begin
      tag_issue.valid   = rd_en;
      tag_issue.pt      = pt_ff;
      tag_issue.first_h = (hk_ff == 3'd0);
      tag_issue.last_h  = (hk_ff == lim);
      tag_issue.first_v = (vk_ff == 3'd0);
      tag_issue.last_v  = (vk_ff == lim);
   end

   always_comb begin
      state_in = state_ff;
      pt_in    = pt_ff;
      vk_in    = vk_ff;
      hk_in    = hk_ff;
      case (state_ff)
         F_IDLE: begin
            if (start) begin
               state_in = F_ISSUE;
               pt_in    = '0;
               vk_in    = '0;
               hk_in    = '0;
            end
         end
         F_ISSUE: begin
            hk_in = hk_ff + 3'd1;
            if (hk_ff == lim) begin
               hk_in = '0;
               vk_in = vk_ff + 3'd1;
               if (vk_ff == lim) begin
                  vk_in = '0;
                  pt_in = pt_ff + 2'd1;
                  if (pt_ff == 2'd3) begin
                     state_in = F_DRAIN;
                  end
               end
            end
         end
         F_DRAIN: begin
            if (tag_f_ff.valid && tag_f_ff.pt == 2'd3) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         pt_ff    <= '0;
         vk_ff    <= '0;
         hk_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pt_ff    <= pt_in;
         vk_ff    <= vk_in;
         hk_ff    <= hk_in;
      end
   end

   // Accumulate row taps, then column taps, then store the point
   assign hsum_in = (tag_d_ff.first_h ? 19'd0 : hsum_ff) + 19'(rd_data);
   assign hb      = geo.smooth ? div5r(hfull_ff) : hfull_ff[HGT_BITS-1:0];
   assign vsum_in = (tag_e_ff.first_v ? 19'd0 : vsum_ff) + 19'(hb);
   assign val     = geo.smooth ? div5r(vfull_ff) : vfull_ff[HGT_BITS-1:0];

   always_comb begin
      tag_e_in       = tag_d_ff;
      tag_e_in.valid = tag_d_ff.valid && tag_d_ff.last_h;
      tag_f_in       = tag_e_ff;
      tag_f_in.valid = tag_e_ff.valid && tag_e_ff.last_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_d_ff <= '0;
         tag_e_ff <= '0;
         tag_f_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         tag_d_ff <= tag_issue;
         tag_e_ff <= tag_e_in;
         tag_f_ff <= tag_f_in;
         done_ff  <= tag_f_ff.valid && tag_f_ff.pt == 2'd3;
      end
   end

   always_ff @(posedge clock) begin
      if (tag_d_ff.valid) begin
         hsum_ff <= hsum_in;
         if (tag_d_ff.last_h) begin
            hfull_ff <= hsum_in;
         end
      end
      if (tag_e_ff.valid) begin
         vsum_ff <= vsum_in;
         if (tag_e_ff.last_v) begin
            vfull_ff <= vsum_in;
         end
      end
      if (tag_f_ff.valid) begin
         hgt_ff[tag_f_ff.pt] <= val;
      end
   end

   assign done = done_ff;
   assign hgt  = hgt_ff;

endmodule

// File: design/hnm_normal.sv
module hnm_normal (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [15:0]                       gain,
   input  logic [3:0][hnm_pkg::HGT_BITS-1:0] hgt,
   output logic                              done,
   output logic [2:0][7:0]                   normal
);
   import hnm_pkg::*;

   norm_state_type state_ff, state_in;
   logic [1:0][23:0] mag_ff, mag_in;
   logic [1:0]       neg_ff, neg_in;
   logic [1:0][47:0] sq_ff;
   logic [63:0]      rv_ff, res_ff, bit_ff, trial;
   logic [1:0]       comp_ff;
   logic [2:0]       step_ff;
   logic [41:0]      rem_ff, dv_ff;
   logic [7:0]       q_ff;
   logic [2:0][7:0]  byte_ff;
   logic             done_ff;
   logic signed [16:0] diff [2];
   logic [15:0]      absd [2];
   logic [31:0]      prod [2];
   logic [31:0]      r;
   logic [23:0]      cval;
   logic             cneg;
   logic [41:0]      cprod, top_lim;
   logic signed [41:0] num;
   logic             q_bit;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         diff[i] = $signed({1'b0, hgt[2*i]}) - $signed({1'b0, hgt[2*i+1]});
         absd[i] = diff[i][16] ? 16'(-diff[i]) : diff[i][15:0];
         prod[i] = 32'(absd[i]) * 32'(gain) + 32'd128;
         mag_in[i] = prod[i][31:8];
         neg_in[i] = (diff[i] > 17'sd0);
      end
   end

   assign r       = res_ff[31:0];
   assign trial   = res_ff + bit_ff;
   assign cval    = (comp_ff == 2'd2) ? 24'd65536 : mag_ff[comp_ff[0]];
   assign cneg    = (comp_ff == 2'd2) ? 1'b0 : neg_ff[comp_ff[0]];
   assign cprod   = 42'(cval) * 42'd16320;
   assign num     = $signed(cneg ? -cprod : cprod) + $signed({2'b00, r, 8'd0});
   assign top_lim = {1'b0, r, 9'd0};
   assign q_bit   = (rem_ff >= dv_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         N_IDLE:      if (start) state_in = N_SLOPE;
         N_SLOPE:     state_in = N_SQUARE;
         N_SQUARE:    state_in = N_ROOT_INIT;
         N_ROOT_INIT: state_in = N_ROOT;
         N_ROOT:      if (bit_ff[0]) state_in = N_DIV_INIT;
         N_DIV_INIT: begin
            if (num > 42'sd0 && $unsigned(num) < top_lim) begin
               state_in = N_DIV;
            end else if (comp_ff == 2'd2) begin
               state_in = N_IDLE;
            end
         end
         N_DIV: begin
            if (step_ff == 3'd7) begin
               state_in = (comp_ff == 2'd2) ? N_IDLE : N_DIV_INIT;
            end
         end
         default: state_in = N_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
         comp_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= 1'b0;
         case (state_ff)
            N_ROOT_INIT: comp_ff <= '0;
            N_DIV_INIT: begin
               step_ff <= '0;
               if (!(num > 42'sd0 && $unsigned(num) < top_lim)) begin
                  comp_ff <= comp_ff + 2'd1;
                  done_ff <= (comp_ff == 2'd2);
               end
            end
            N_DIV: begin
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd7) begin
                  comp_ff <= comp_ff + 2'd1;
                  done_ff <= (comp_ff == 2'd2);
               end
            end
            default: step_ff <= '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         N_SLOPE: begin
            mag_ff <= mag_in;
            neg_ff <= neg_in;
         end
         N_SQUARE: begin
            sq_ff[0] <= 48'(mag_ff[0]) * 48'(mag_ff[0]);
            sq_ff[1] <= 48'(mag_ff[1]) * 48'(mag_ff[1]);
         end
         N_ROOT_INIT: begin
            rv_ff  <= (64'(sq_ff[0]) + 64'(sq_ff[1]) + 64'h1_0000_0000) << 12;
            res_ff <= '0;
            bit_ff <= 64'h4000_0000_0000_0000;
         end
         N_ROOT: begin
            // one result bit per cycle
            if (rv_ff >= trial) begin
               rv_ff  <= rv_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         N_DIV_INIT: begin
            rem_ff <= $unsigned(num);
            dv_ff  <= {2'b00, r, 8'd0};
            q_ff   <= '0;
            if (num <= 42'sd0) begin
               byte_ff[comp_ff] <= 8'd0;
            end else if ($unsigned(num) >= top_lim) begin
               byte_ff[comp_ff] <= 8'd255;
            end
         end
         N_DIV: begin
            if (q_bit) begin
               rem_ff <= rem_ff - dv_ff;
            end
            dv_ff <= dv_ff >> 1;
            q_ff  <= {q_ff[6:0], q_bit};
            if (step_ff == 3'd7) begin
               byte_ff[comp_ff] <= {q_ff[6:0], q_bit};
            end
         end
         default: rem_ff <= rem_ff;
      endcase
   end

   assign done   = done_ff;
   assign normal = byte_ff;

endmodule

// File: design/height_to_normal_map.sv
// Height-map to normal-map converter.
// req_* carries raster-order RGB pixels (tuser = 0) or flush items (tuser = 1).
// Each pixel becomes a 16-bit luma height kept in a 16-row ring of line memory;
// in smooth mode a 5x5 box blur is applied, then clamped central differences,
// bump gain and normalization give one RGB-style normal byte triple on rsp_*.
// rsp_tlast marks the last normal of the frame. csr_* writes the geometry,
// gain and mode; the user must write them only while the block is idle (the
// block does not enforce it). Geometry and mode apply at a frame's first pixel.
// Output for pixel o appears once pixel o+L*W+L is in (L = 3 smooth, 1 sharp);
// after the frame is complete, each further item releases one pending normal.
// An item that releases no normal does not hold the input. One that releases
// a normal holds the input for the line-memory reads (4 in sharp mode, 100 in
// smooth mode, one read port) plus the arithmetic, dominated by the 32-step
// square root and up to three byte divisions.
// Reset clears all counters and loads register defaults (256 x 256, gain 1.0,
// sharp); line memory is not cleared. A stalled rsp_tready holds the finished
// normal in the output register; the next item may still be taken meanwhile.
module height_to_normal_map (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red, green, blue
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // normal_x, normal_y, normal_z
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import hnm_pkg::*;

   top_state_type state_ff, state_in;
   dim_type    cfg_w_ff, cfg_h_ff;
   logic [15:0] cfg_gain_ff;
   logic       cfg_smooth_ff;
   geo_type    geo_ff, geo_in;
   coord_type  col_ff, ox_ff, oy_ff, cur_x_ff, cur_y_ff;
   dim_type    row_ff;
   logic [24:0] rx_ff;
   logic [23:0] out_ff;
   logic       in_done_ff, fe_ff;
   logic       acc, is_pix, latch, emit, emit_pix, frame_end, wrap_x;
   logic [12:0] col_inc, ox_inc;
   logic [14:0] lag;
   logic       fetch_start, fetch_done, calc_start, calc_done, out_load;
   logic       rd_en;
   addr_type   rd_addr;
   hgt_type    rd_data;
   logic [3:0][HGT_BITS-1:0] hgt;
   logic [2:0][7:0] normal;
   logic       rsp_valid_ff, rsp_last_ff;
   logic [23:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff      <= 13'd256;
         cfg_h_ff      <= 13'd256;
         cfg_gain_ff   <= 16'd256;
         cfg_smooth_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:  cfg_w_ff      <= csr_wdata[12:0];
            CSR_HEIGHT: cfg_h_ff      <= csr_wdata[12:0];
            CSR_GAIN:   cfg_gain_ff   <= csr_wdata;
            CSR_SMOOTH: cfg_smooth_ff <= csr_wdata[0];
            default:    cfg_gain_ff   <= cfg_gain_ff;
         endcase
      end
   end

   assign req_tready = (state_ff == T_IDLE);
   assign acc    = req_tvalid && req_tready;
   assign is_pix = acc && req_tuser == KIND_PIXEL && !in_done_ff;
   assign latch  = is_pix && row_ff == '0 && col_ff == '0 && out_ff == '0;

   always_comb begin
      geo_in = geo_ff;
      if (latch) begin
         geo_in.w      = clamp_dim(cfg_w_ff, 13'(MAX_WIDTH));
         geo_in.h      = clamp_dim(cfg_h_ff, 13'(MAX_HEIGHT));
         geo_in.smooth = cfg_smooth_ff;
      end
   end

   assign col_inc   = {1'b0, col_ff} + 13'd1;
   assign wrap_x    = (col_inc >= geo_in.w);
   assign lag       = geo_in.smooth ? ({1'b0, geo_in.w, 1'b0} + 15'(geo_in.w) + 15'd3)
                                    : (15'(geo_in.w) + 15'd1);
   assign emit_pix  = is_pix && ((rx_ff + 25'd1) > (25'(out_ff) + 25'(lag)));
   assign emit      = emit_pix || (acc && !is_pix && in_done_ff);
   assign ox_inc    = {1'b0, ox_ff} + 13'd1;
   assign frame_end = (ox_inc == geo_in.w) && ({1'b0, oy_ff} + 13'd1 == geo_in.h);

   always_ff @(posedge clock) begin
      if (reset) begin
         geo_ff     <= '{w: 13'd256, h: 13'd256, smooth: 1'b0};
         col_ff     <= '0;
         row_ff     <= '0;
         rx_ff      <= '0;
         out_ff     <= '0;
         ox_ff      <= '0;
         oy_ff      <= '0;
         in_done_ff <= 1'b0;
      end else begin
         geo_ff <= geo_in;
         if (is_pix) begin
            col_ff     <= wrap_x ? '0 : col_inc[COL_BITS-1:0];
            row_ff     <= row_ff + 13'(wrap_x);
            in_done_ff <= (row_ff + 13'(wrap_x)) >= geo_in.h;
            rx_ff      <= rx_ff + 25'd1;
         end
         if (emit) begin
            if (frame_end) begin
               // frame complete: rewind everything for the next one
               col_ff     <= '0;
               row_ff     <= '0;
               rx_ff      <= '0;
               out_ff     <= '0;
               ox_ff      <= '0;
               oy_ff      <= '0;
               in_done_ff <= 1'b0;
            end else begin
               out_ff <= out_ff + 24'd1;
               if (ox_inc == geo_in.w) begin
                  ox_ff <= '0;
                  oy_ff <= oy_ff + 12'd1;
               end else begin
                  ox_ff <= ox_inc[COL_BITS-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         cur_x_ff <= ox_ff;
         cur_y_ff <= oy_ff;
         fe_ff    <= frame_end;
      end
   end

   assign fetch_start = (state_ff == T_IDLE) && emit;
   assign calc_start  = (state_ff == T_FETCH) && fetch_done;
   assign out_load    = (state_ff == T_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         T_IDLE:  if (emit) state_in = T_FETCH;
         T_FETCH: if (fetch_done) state_in = T_CALC;
         T_CALC:  if (calc_done) state_in = T_OUT;
         T_OUT:   if (out_load) state_in = T_IDLE;
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= normal;
         rsp_last_ff <= fe_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   hnm_ram #(
      .WIDTH (HGT_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_lines (
      .clock   (clock),
      .wr_en   (is_pix),
      .wr_addr ({row_ff[RING_BITS-1:0], col_ff}),
      .wr_data (luma(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16])),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hnm_fetch u_fetch (
      .clock   (clock),
      .reset   (reset),
      .start   (fetch_start),
      .geo     (geo_ff),
      .ox      (cur_x_ff),
      .oy      (cur_y_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .done    (fetch_done),
      .hgt     (hgt)
   );

   hnm_normal u_normal (
      .clock  (clock),
      .reset  (reset),
      .start  (calc_start),
      .gain   (cfg_gain_ff),
      .hgt    (hgt),
      .done   (calc_done),
      .normal (normal)
   );

endmodule
